/* rtl/tst_pkg.sv */
// Shared constants and types for the timeout slot table.
package tst_pkg;

  localparam int SLOTS  = 64;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ID_W   = 32;
  localparam int TIME_W = 32;
  localparam int TLEN_W = 31;
  localparam int CTX_W  = 64;
  localparam int MODE_W = 2;
  localparam int KIND_W = 2;

  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_CREATED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic [TIME_W-1:0]        start;
    logic [TLEN_W-1:0]        timeout;
    logic signed [CTX_W-1:0]  ctx;
  } slot_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_t            data;
  } slot_wr_t;

endpackage

/* rtl/tst_slot_store.sv */
// Slot payload memory: one write port, one registered read port.
module tst_slot_store import tst_pkg::*; (
  input  logic             clk,
  input  slot_wr_t         wr,
  input  logic [IDX_W-1:0] rd_addr,
  output slot_t            rd_data
);

  slot_t mem [SLOTS];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/timeout_slot_table.sv */
// Timeout slot table: create, cancel and expiry check over a fixed slot table.
//
// A request is taken when start is high and busy is low; busy then stays high
// until the request is done. Mode 3 is taken, does nothing and leaves busy low.
// One slot is visited per cycle by a single index counter, with payload read
// from the slot memory in the cycle before its visit. Create scans up to the
// lowest free slot, cancel up to the matching slot, check over every slot and
// then a flush step. Each result shows for one cycle under out_valid and cannot
// be held off. No clearing pass follows reset: the active marks clear at once.
module timeout_slot_table import tst_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [TIME_W-1:0]       in_now_seconds,
  input  logic [TLEN_W-1:0]       in_timeout_len,
  input  logic signed [CTX_W-1:0] in_context_value,
  input  logic [ID_W-1:0]         in_target_id,
  output logic                    out_valid,
  output logic [KIND_W-1:0]       out_kind,
  output logic [ID_W-1:0]         out_assigned_id,
  output logic signed [CTX_W-1:0] out_expired_context,
  output logic                    out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_CANCEL,
    S_CHECK,
    S_FLUSH
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SLOTS-1:0]        active_r, active_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [ID_W-1:0]         id_cnt_r, id_cnt_nxt;
  logic [TIME_W-1:0]       now_r, now_nxt;
  logic [TLEN_W-1:0]       tlen_r, tlen_nxt;
  logic signed [CTX_W-1:0] ctx_r, ctx_nxt;
  logic [ID_W-1:0]         target_r, target_nxt;
  logic                    pend_valid_r, pend_valid_nxt;
  logic [ID_W-1:0]         pend_id_r, pend_id_nxt;
  logic signed [CTX_W-1:0] pend_ctx_r, pend_ctx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]       out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]         out_id_r, out_id_nxt;
  logic signed [CTX_W-1:0] out_ctx_r, out_ctx_nxt;
  logic                    out_last_r, out_last_nxt;

  slot_wr_t                wr;
  slot_t                   rd;
  logic [TIME_W-1:0]       diff;
  logic                    at_end;
  logic                    hit;

  tst_slot_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (idx_nxt),
    .rd_data (rd)
  );

  assign at_end = (idx_r == IDX_W'(SLOTS - 1));
  assign diff   = now_r - rd.start;
  assign hit    = active_r[idx_r] && !diff[TIME_W-1] && (diff[TLEN_W-1:0] >= rd.timeout);

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    idx_nxt        = idx_r;
    id_cnt_nxt     = id_cnt_r;
    now_nxt        = now_r;
    tlen_nxt       = tlen_r;
    ctx_nxt        = ctx_r;
    target_nxt     = target_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    pend_ctx_nxt   = pend_ctx_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_ctx_nxt    = out_ctx_r;
    out_last_nxt   = out_last_r;
    wr             = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          now_nxt        = in_now_seconds;
          tlen_nxt       = in_timeout_len;
          ctx_nxt        = in_context_value;
          target_nxt     = in_target_id;
          idx_nxt        = '0;
          pend_valid_nxt = 1'b0;
          unique case (in_mode)
            MODE_CREATE: state_nxt = S_FIND;
            MODE_CANCEL: state_nxt = S_CANCEL;
            MODE_CHECK:  state_nxt = S_CHECK;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_FIND: begin
        if (!active_r[idx_r]) begin
          wr.en              = 1'b1;
          wr.addr            = idx_r;
          wr.data.id         = id_cnt_r;
          wr.data.start      = now_r;
          wr.data.timeout    = tlen_r;
          wr.data.ctx        = ctx_r;
          active_nxt[idx_r]  = 1'b1;
          id_cnt_nxt         = id_cnt_r + ID_W'(1);
          out_valid_nxt      = 1'b1;
          out_kind_nxt       = KIND_CREATED;
          out_id_nxt         = id_cnt_r;
          out_ctx_nxt        = '0;
          out_last_nxt       = 1'b1;
          state_nxt          = S_IDLE;
        end else if (at_end) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FULL;
          out_id_nxt    = '0;
          out_ctx_nxt   = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_CANCEL: begin
        if (active_r[idx_r] && (rd.id == target_r)) begin
          active_nxt[idx_r] = 1'b0;
          state_nxt         = S_IDLE;
        end else if (at_end) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_CHECK: begin
        if (hit) begin
          active_nxt[idx_r] = 1'b0;
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_EXPIRED;
            out_id_nxt    = pend_id_r;
            out_ctx_nxt   = pend_ctx_r;
            out_last_nxt  = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_id_nxt    = rd.id;
          pend_ctx_nxt   = rd.ctx;
        end
        if (at_end) begin
          state_nxt = S_FLUSH;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_FLUSH: begin
        if (pend_valid_r) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_EXPIRED;
          out_id_nxt    = pend_id_r;
          out_ctx_nxt   = pend_ctx_r;
          out_last_nxt  = 1'b1;
        end
        pend_valid_nxt = 1'b0;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    now_r      <= now_nxt;
    tlen_r     <= tlen_nxt;
    ctx_r      <= ctx_nxt;
    target_r   <= target_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_ctx_r <= pend_ctx_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_ctx_r  <= out_ctx_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= '0;
      id_cnt_r     <= ID_W'(1);
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      id_cnt_r     <= id_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_assigned_id     = out_id_r;
  assign out_expired_context = out_ctx_r;
  assign out_last            = out_last_r;

endmodule

/* rtl/tst_checker.sv */
// Port-level checks for the timeout slot table, bound to the top level.
module tst_checker import tst_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic [MODE_W-1:0]       in_mode,
  input logic                    out_valid,
  input logic [KIND_W-1:0]       out_kind,
  input logic [ID_W-1:0]         out_assigned_id,
  input logic signed [CTX_W-1:0] out_expired_context,
  input logic                    out_last
);

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_mode == MODE_CREATE || in_mode == MODE_CANCEL ||
                       in_mode == MODE_CHECK) |=> busy)
    else $error("busy not raised after request");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_CREATED || out_kind == KIND_FULL ||
                   out_kind == KIND_EXPIRED))
    else $error("illegal result kind");

  a_create_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_CREATED || out_kind == KIND_FULL) |->
      out_last && (out_expired_context == '0))
    else $error("create result malformed");

  a_full_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_FULL) |-> (out_assigned_id == '0))
    else $error("table-full result carries an id");

  a_no_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid || $past(!busy))
    else $error("result after final result of a request");

endmodule

bind timeout_slot_table tst_checker u_tst_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_mode             (in_mode),
  .out_valid           (out_valid),
  .out_kind            (out_kind),
  .out_assigned_id     (out_assigned_id),
  .out_expired_context (out_expired_context),
  .out_last            (out_last)
);

/* test/timeout_slot_table_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for timeout_slot_table: directed table, then random request traffic.
module timeout_slot_table_tb;
  import tst_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int PHASE_ITEMS    = 133;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 200;
  localparam int PRINT_CAP      = 40;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [TIME_W-1:0]       now;
    logic [TLEN_W-1:0]       tlen;
    logic signed [CTX_W-1:0] ctx;
    logic [ID_W-1:0]         target;
  } timer_req_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [ID_W-1:0]         id;
    logic signed [CTX_W-1:0] ctx;
    logic                    last;
  } timer_report_t;

  typedef struct packed {
    timer_req_t    req;
    logic          fixed;
    timer_report_t want;
  } directed_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [MODE_W-1:0]       in_mode = MODE_CREATE;
  logic [TIME_W-1:0]       in_now_seconds = '0;
  logic [TLEN_W-1:0]       in_timeout_len = '0;
  logic signed [CTX_W-1:0] in_context_value = '0;
  logic [ID_W-1:0]         in_target_id = '0;
  logic                    out_valid;
  logic [KIND_W-1:0]       out_kind;
  logic [ID_W-1:0]         out_assigned_id;
  logic signed [CTX_W-1:0] out_expired_context;
  logic                    out_last;

  logic            slot_live [SLOTS];
  slot_t           slot_mem  [SLOTS];
  logic [ID_W-1:0] model_id_cnt;
  logic [TIME_W-1:0] wall_secs;
  timer_report_t   fresh_reports [$];
  timer_report_t   awaited_reports [$];
  directed_row_t   directed_rows [$];
  int              mismatch_count = 0;
  int              stall_cycles = 0;

  timeout_slot_table dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_now_seconds      (in_now_seconds),
    .in_timeout_len      (in_timeout_len),
    .in_context_value    (in_context_value),
    .in_target_id        (in_target_id),
    .out_valid           (out_valid),
    .out_kind            (out_kind),
    .out_assigned_id     (out_assigned_id),
    .out_expired_context (out_expired_context),
    .out_last            (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic note_mismatch(input string what, input logic [CTX_W-1:0] seen,
                               input logic [CTX_W-1:0] wanted);
    if (mismatch_count < PRINT_CAP)
      $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, seen, wanted);
    mismatch_count++;
  endtask

  function automatic void apply_request(input timer_req_t r);
    logic [TIME_W-1:0] elapsed;
    logic              done;
    timer_report_t     rep;
    done = 1'b0;
    fresh_reports.delete();
    case (r.mode)
      MODE_CREATE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && !slot_live[i]) begin
            slot_mem[i].id      = model_id_cnt;
            slot_mem[i].start   = r.now;
            slot_mem[i].timeout = r.tlen;
            slot_mem[i].ctx     = r.ctx;
            slot_live[i]        = 1'b1;
            rep = '{kind: KIND_CREATED, id: model_id_cnt, ctx: '0, last: 1'b1};
            model_id_cnt = model_id_cnt + 1'b1;
            done = 1'b1;
          end
        end
        if (!done)
          rep = '{kind: KIND_FULL, id: '0, ctx: '0, last: 1'b1};
        fresh_reports.push_back(rep);
      end
      MODE_CANCEL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && slot_live[i] && slot_mem[i].id == r.target) begin
            slot_live[i] = 1'b0;
            done = 1'b1;
          end
        end
      end
      MODE_CHECK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i]) begin
            elapsed = r.now - slot_mem[i].start;
            if (!elapsed[TIME_W-1] && elapsed >= TIME_W'(slot_mem[i].timeout)) begin
              slot_live[i] = 1'b0;
              rep = '{kind: KIND_EXPIRED, id: slot_mem[i].id, ctx: slot_mem[i].ctx,
                      last: 1'b0};
              fresh_reports.push_back(rep);
            end
          end
        end
        if (fresh_reports.size() > 0) begin
          rep = fresh_reports.pop_back();
          rep.last = 1'b1;
          fresh_reports.push_back(rep);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(input logic [MODE_W-1:0] mode,
                                  input logic [TIME_W-1:0] now,
                                  input logic [TLEN_W-1:0] tlen,
                                  input logic signed [CTX_W-1:0] ctx,
                                  input logic [ID_W-1:0] target,
                                  input logic [ID_W-1:0] fixed_id);
    directed_row_t row;
    row.req   = '{mode: mode, now: now, tlen: tlen, ctx: ctx, target: target};
    row.fixed = (fixed_id != '0);
    row.want  = '{kind: KIND_CREATED, id: fixed_id, ctx: '0, last: 1'b1};
    directed_rows.push_back(row);
  endfunction

  task automatic issue_request(input timer_req_t r, input int gap_pct, input logic fixed,
                               input timer_report_t want);
    while ($urandom_range(99, 0) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    in_mode          <= r.mode;
    in_now_seconds   <= r.now;
    in_timeout_len   <= r.tlen;
    in_context_value <= r.ctx;
    in_target_id     <= r.target;
    do @(posedge clk); while (busy !== 1'b0);
    apply_request(r);
    if (fixed)
      awaited_reports.push_back(want);
    else
      foreach (fresh_reports[k]) awaited_reports.push_back(fresh_reports[k]);
  endtask

  function automatic timer_req_t random_item(input int pick);
    timer_req_t r;
    int         base;
    int         roll;
    logic       found;
    r.mode   = MODE_SPARE;
    r.now    = $urandom();
    r.tlen   = TLEN_W'($urandom());
    r.ctx    = {$urandom(), $urandom()};
    r.target = $urandom();
    found    = 1'b0;
    wall_secs = wall_secs + TIME_W'($urandom_range(3, 0));
    if (pick < 46) begin
      r.mode = MODE_CREATE;
      r.now  = wall_secs;
      if ($urandom_range(99, 0) < 85)
        r.tlen = TLEN_W'($urandom_range(40, 0));
    end else if (pick < 71) begin
      r.mode = MODE_CANCEL;
      base   = $urandom_range(SLOTS - 1, 0);
      roll   = $urandom_range(99, 0);
      if (roll < 80) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && slot_live[(base + i) % SLOTS]) begin
            r.target = slot_mem[(base + i) % SLOTS].id;
            found = 1'b1;
          end
        end
      end else if (roll < 90) begin
        r.target = model_id_cnt - 1'b1;
      end
    end else if (pick < 96) begin
      r.mode = MODE_CHECK;
      wall_secs = wall_secs + TIME_W'($urandom_range(30, 0));
      roll = $urandom_range(99, 0);
      if (roll >= 15)
        r.now = wall_secs;
      else if (roll >= 10)
        r.now = wall_secs + 32'h7FFF_0000;
    end
    return r;
  endfunction

  task automatic random_phase(input int gap_pct);
    int         taken;
    int         pick;
    int         live;
    timer_req_t r;
    taken = 0;
    while (taken < PHASE_ITEMS) begin
      pick = $urandom_range(99, 0);
      if (pick < 5) begin
        // fill the table, then push past full
        live = 0;
        foreach (slot_live[i]) live += slot_live[i];
        repeat (SLOTS - live + $urandom_range(3, 1)) begin
          r = random_item(0);
          issue_request(r, gap_pct, 1'b0, '0);
          taken++;
        end
      end else begin
        r = random_item(pick);
        issue_request(r, gap_pct, 1'b0, '0);
        taken++;
      end
    end
  endtask

  always @(posedge clk) begin
    timer_report_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (awaited_reports.size() == 0) begin
        note_mismatch("unexpected result id", CTX_W'(out_assigned_id), '0);
      end else begin
        want = awaited_reports.pop_front();
        if (out_kind !== want.kind)
          note_mismatch("kind", CTX_W'(out_kind), CTX_W'(want.kind));
        if (out_assigned_id !== want.id)
          note_mismatch("assigned_id", CTX_W'(out_assigned_id), CTX_W'(want.id));
        if (out_expired_context !== want.ctx)
          note_mismatch("expired_context", out_expired_context, want.ctx);
        if (out_last !== want.last)
          note_mismatch("last", CTX_W'(out_last), CTX_W'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    model_id_cnt = 1;
    foreach (slot_live[i]) slot_live[i] = 1'b0;
    wall_secs = $urandom();

    add_row(MODE_CHECK,  32'h0000_0000, 31'd0, 64'sd0, 32'd0, 32'd0);
    add_row(MODE_CREATE, 32'h0000_0000, 31'd0, 64'sh7FFF_FFFF_FFFF_FFFF, 32'd0, 32'd1);
    add_row(MODE_CREATE, 32'h0000_0000, 31'h7FFF_FFFF, 64'sh8000_0000_0000_0000, 32'd0,
            32'd2);
    add_row(MODE_CREATE, 32'hFFFF_FFF0, 31'd16, -64'sd1, 32'd0, 32'd3);
    add_row(MODE_CREATE, 32'd100, 31'd5, 64'sd0, 32'd0, 32'd4);
    add_row(MODE_SPARE,  32'hFFFF_FFFF, 31'h7FFF_FFFF, -64'sd1, 32'hFFFF_FFFF, 32'd0);
    add_row(MODE_CANCEL, 32'd0, 31'd0, 64'sd0, 32'hFFFF_FFFF, 32'd0);
    add_row(MODE_CANCEL, 32'hFFFF_FFFF, 31'h7FFF_FFFF, -64'sd1, 32'd0, 32'd0);
    add_row(MODE_CHECK,  32'h0000_0000, 31'd0, 64'sd0, 32'd0, 32'd0);
    add_row(MODE_CANCEL, 32'd0, 31'd0, 64'sd0, 32'd4, 32'd0);
    add_row(MODE_CHECK,  32'd1000, 31'd0, 64'sd0, 32'd0, 32'd0);
    add_row(MODE_CREATE, 32'd5, 31'd1, 64'sh0123_4567_89AB_CDEF, 32'd0, 32'd0);
    add_row(MODE_CREATE, 32'd5, 31'd3, 64'shFEDC_BA98_7654_3210, 32'd0, 32'd0);
    add_row(MODE_CANCEL, 32'd0, 31'd0, 64'sd0, 32'd6, 32'd0);
    add_row(MODE_CANCEL, 32'd0, 31'd0, 64'sd0, 32'd6, 32'd0);
    add_row(MODE_CHECK,  32'h7FFF_FFFF, 31'd0, 64'sd0, 32'd0, 32'd0);
    add_row(MODE_CREATE, 32'h8000_0000, 31'd0, 64'sd1, 32'd0, 32'd0);
    add_row(MODE_CHECK,  32'h0000_0000, 31'd0, 64'sd0, 32'd0, 32'd0);
    add_row(MODE_CHECK,  32'h8000_0000, 31'd0, 64'sd0, 32'd0, 32'd0);
    add_row(MODE_CREATE, 32'hFFFF_FFFF, 31'h2AAA_AAAA, 64'shAAAA_5555_AAAA_5555, 32'd0,
            32'd0);
    add_row(MODE_CANCEL, 32'h5555_5555, 31'h5555_5555, 64'sh5555_AAAA_5555_AAAA, 32'd8,
            32'd0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k])
      issue_request(directed_rows[k].req, 18, directed_rows[k].fixed, directed_rows[k].want);

    random_phase(18);
    random_phase(66);
    random_phase(0);
    start <= 1'b0;

    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
